@@ src/hsv_to_rgb_converter_macros.svh @@
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication
`define HSV_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_converter: assertion failed");

// next-cycle implication
`define HSV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_converter: assertion failed");

`endif

@@ src/hsv2rgb_pkg.sv @@
`default_nettype none

package hsv2rgb_pkg;

  localparam int COLOR_BITS_DEF    = 8;
  localparam int HUE_FRAC_BITS_DEF = 4;

  // 60-degree hue sectors, hexcone order
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

endpackage

`default_nettype wire

@@ src/hsv_to_rgb_converter.sv @@
// HSV to RGB converter, six-sector hexcone rule, exact fixed point.
// Throughput: one transaction per cycle while the output is not stalled; each
// of the 9 stages moves on its own when the stage after it is empty or moving,
// so bubbles are squeezed out.
// Reset (rst, synchronous): clears all stage valid bits; data registers keep.
`default_nettype none
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter #(
  parameter int COLOR_BITS    = hsv2rgb_pkg::COLOR_BITS_DEF,
  parameter int HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_BITS_DEF,
  localparam int HUE_W = 9 + HUE_FRAC_BITS,
  localparam int IN_W  = ((HUE_W + 2 * COLOR_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COLOR_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,  // hue, saturation, brightness
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata   // red, green, blue
);

  import hsv2rgb_pkg::*;

  localparam int CB     = COLOR_BITS;
  localparam int NS     = 9;
  localparam int SECT   = 60 * (2 ** HUE_FRAC_BITS);
  localparam int CIRCLE = 6 * SECT;
  localparam int HALF_W = HUE_FRAC_BITS + 7;
  localparam int WGT_W  = HUE_FRAC_BITS + 6;
  localparam int CHR_W  = 2 * CB;
  localparam int PROD_W = CHR_W + WGT_W;
  localparam int XW     = PROD_W - (HUE_FRAC_BITS + 2);
  // divide by 15: x = xh*2^L + xl, 2^L = 15*K + 1
  localparam int SUB_DIV = 15;
  localparam int L      = 4 * ((XW + 7) / 8);
  localparam int XH_W   = XW - L;
  localparam int K_W    = L - 3;
  localparam int YW     = L + 1;
  localparam int RK     = YW + 4;
  localparam int M_W    = RK - 3;
  localparam int QW     = L - 2;
  localparam int YX     = YW + 4;

  localparam logic [HUE_W-1:0]  CIRCLE_C = HUE_W'(CIRCLE);
  localparam logic [HUE_W-1:0]  TH1      = HUE_W'(SECT);
  localparam logic [HUE_W-1:0]  TH2      = HUE_W'(2 * SECT);
  localparam logic [HUE_W-1:0]  TH3      = HUE_W'(3 * SECT);
  localparam logic [HUE_W-1:0]  TH4      = HUE_W'(4 * SECT);
  localparam logic [HUE_W-1:0]  TH5      = HUE_W'(5 * SECT);
  localparam logic [HALF_W-1:0] SECT_H   = HALF_W'(SECT);
  localparam logic [HALF_W-1:0] TWO_S_H  = HALF_W'(2 * SECT);
  localparam logic [K_W-1:0]    K        = K_W'((2 ** L - 1) / SUB_DIV);
  localparam logic [M_W-1:0]    M        = M_W'((2 ** RK + SUB_DIV - 1) / SUB_DIV);

  // floor(s / (2^CB - 1)), exact for s <= (2^CB - 1)^2
  function automatic logic [CB-1:0] div_maxc(input logic [CHR_W-1:0] s);
    logic [CHR_W:0] t;
    t = {1'b0, s} + (CHR_W + 1)'(s >> CB) + (CHR_W + 1)'(1);
    return t[CHR_W-1:CB];
  endfunction

  logic [NS:1] vld;
  logic [NS:1] adv;

  always_comb begin
    adv[NS] = !vld[NS] || m_axis_tready;
    for (int i = NS - 1; i >= 1; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign s_axis_tready = adv[1];
  assign m_axis_tvalid = vld[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= s_axis_tvalid;
      end
      for (int i = 2; i <= NS; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: hue wrap, chroma
  logic [HUE_W-1:0] hue_in;
  logic [CB-1:0]    sat_in;
  logic [CB-1:0]    bri_in;
  logic [CHR_W-1:0] chroma_c;

  assign hue_in   = s_axis_tdata[HUE_W-1:0];
  assign sat_in   = s_axis_tdata[HUE_W +: CB];
  assign bri_in   = s_axis_tdata[HUE_W + CB +: CB];
  assign chroma_c = CHR_W'(sat_in) * CHR_W'(bri_in);

  logic [HUE_W-1:0] hue1;
  logic [CB-1:0]    val1;
  logic [CHR_W-1:0] chroma1;

  // stage 2: sector, position in double sector, offset
  sector_t          sec_c;
  logic [HUE_W-1:0] base_c;
  logic [HUE_W-1:0] half_c;
  logic [CHR_W-1:0] offset_c;

  always_comb begin
    priority if (hue1 >= TH5) begin
      sec_c = SEC_MR;
    end else if (hue1 >= TH4) begin
      sec_c = SEC_BM;
    end else if (hue1 >= TH3) begin
      sec_c = SEC_CB;
    end else if (hue1 >= TH2) begin
      sec_c = SEC_GC;
    end else if (hue1 >= TH1) begin
      sec_c = SEC_YG;
    end else begin
      sec_c = SEC_RY;
    end
    unique case (sec_c)
      SEC_RY, SEC_YG: begin
        base_c = '0;
      end
      SEC_GC, SEC_CB: begin
        base_c = TH2;
      end
      default: begin
        base_c = TH4;
      end
    endcase
  end

  assign half_c   = hue1 - base_c;
  assign offset_c = {val1, {CB{1'b0}}} - CHR_W'(val1) - chroma1;

  sector_t           sector2;
  logic [HALF_W-1:0] half2;
  logic [CHR_W-1:0]  chroma2;
  logic [CHR_W-1:0]  offset2;

  // stage 3: weight = SECT - |half - SECT|
  logic [HALF_W-1:0] weight_c;
  assign weight_c = (half2 < SECT_H) ? half2 : (TWO_S_H - half2);

  sector_t          sector3;
  logic [WGT_W-1:0] weight3;
  logic [CHR_W-1:0] chroma3;
  logic [CHR_W-1:0] offset3;

  // stage 4: chroma * weight, power-of-two factor of SECT (HUE_FRAC_BITS + 2 low bits) dropped
  logic [PROD_W-1:0] prod_c;
  assign prod_c = PROD_W'(chroma3) * PROD_W'(weight3);

  sector_t          sector4;
  logic [XW-1:0]    x4;
  logic [CHR_W-1:0] chroma4;
  logic [CHR_W-1:0] offset4;

  // stage 5: fold for the divide by 15
  logic [XH_W-1:0]     xh_c;
  logic [L-1:0]        xl_c;
  logic [K_W+XH_W-1:0] kx_c;
  logic [YW-1:0]       y_c;

  assign xh_c = x4[XW-1:L];
  assign xl_c = x4[L-1:0];
  assign kx_c = (K_W + XH_W)'(K) * (K_W + XH_W)'(xh_c);
  assign y_c  = YW'(xh_c) + YW'(xl_c);

  sector_t          sector5;
  logic [CHR_W-1:0] kx5;
  logic [YW-1:0]    y5;
  logic [CHR_W-1:0] chroma5;
  logic [CHR_W-1:0] offset5;

  // stage 6: small quotient by reciprocal
  logic [YW+M_W-1:0] ym_c;
  assign ym_c = (YW + M_W)'(y5) * (YW + M_W)'(M);

  sector_t          sector6;
  logic [CHR_W-1:0] kx6;
  logic [QW-1:0]    qy6;
  logic [YW-1:0]    y6;
  logic [CHR_W-1:0] chroma6;
  logic [CHR_W-1:0] offset6;

  // stage 7: secondary term
  logic [CHR_W-1:0] second_c;
  assign second_c = kx6 + CHR_W'(qy6);

  sector_t          sector7;
  logic [CHR_W-1:0] second7;
  logic [CHR_W-1:0] chroma7;
  logic [CHR_W-1:0] offset7;

  // stage 8: rotate primes, add offset
  logic [CHR_W-1:0] rp_c;
  logic [CHR_W-1:0] gp_c;
  logic [CHR_W-1:0] bp_c;

  always_comb begin
    rp_c = '0;
    gp_c = '0;
    bp_c = '0;
    unique case (sector7)
      SEC_RY: begin
        rp_c = chroma7;
        gp_c = second7;
      end
      SEC_YG: begin
        rp_c = second7;
        gp_c = chroma7;
      end
      SEC_GC: begin
        gp_c = chroma7;
        bp_c = second7;
      end
      SEC_CB: begin
        gp_c = second7;
        bp_c = chroma7;
      end
      SEC_BM: begin
        rp_c = second7;
        bp_c = chroma7;
      end
      default: begin
        rp_c = chroma7;
        bp_c = second7;
      end
    endcase
  end

  logic [CHR_W-1:0] sum_r8;
  logic [CHR_W-1:0] sum_g8;
  logic [CHR_W-1:0] sum_b8;

  // stage 9: scale back to channel range
  logic [CB-1:0] red9;
  logic [CB-1:0] green9;
  logic [CB-1:0] blue9;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      hue1    <= (hue_in >= CIRCLE_C) ? (hue_in - CIRCLE_C) : hue_in;
      val1    <= bri_in;
      chroma1 <= chroma_c;
    end
    if (adv[2]) begin
      sector2 <= sec_c;
      half2   <= half_c[HALF_W-1:0];
      chroma2 <= chroma1;
      offset2 <= offset_c;
    end
    if (adv[3]) begin
      sector3 <= sector2;
      weight3 <= weight_c[WGT_W-1:0];
      chroma3 <= chroma2;
      offset3 <= offset2;
    end
    if (adv[4]) begin
      sector4 <= sector3;
      x4      <= prod_c[PROD_W-1:HUE_FRAC_BITS+2];
      chroma4 <= chroma3;
      offset4 <= offset3;
    end
    if (adv[5]) begin
      sector5 <= sector4;
      kx5     <= kx_c[CHR_W-1:0];
      y5      <= y_c;
      chroma5 <= chroma4;
      offset5 <= offset4;
    end
    if (adv[6]) begin
      sector6 <= sector5;
      kx6     <= kx5;
      qy6     <= ym_c[YW+M_W-1:RK];
      y6      <= y5;
      chroma6 <= chroma5;
      offset6 <= offset5;
    end
    if (adv[7]) begin
      sector7 <= sector6;
      second7 <= second_c;
      chroma7 <= chroma6;
      offset7 <= offset6;
    end
    if (adv[8]) begin
      sum_r8 <= rp_c + offset7;
      sum_g8 <= gp_c + offset7;
      sum_b8 <= bp_c + offset7;
    end
    if (adv[9]) begin
      red9   <= div_maxc(sum_r8);
      green9 <= div_maxc(sum_g8);
      blue9  <= div_maxc(sum_b8);
    end
  end

  assign m_axis_tdata = OUT_W'({blue9, green9, red9});

  logic [YX-1:0] q15_6;
  assign q15_6 = YX'(qy6) * YX'(SUB_DIV);

  `HSV_ASSERT(a_full_blocks_input, clk, rst, (&vld) && !m_axis_tready, !s_axis_tready)
  `HSV_ASSERT(a_div15_remainder, clk, rst, vld[6], (q15_6 <= YX'(y6)) && (YX'(y6) < q15_6 + YX'(SUB_DIV)))
  `HSV_ASSERT(a_second_le_chroma, clk, rst, vld[7], second7 <= chroma7)
  `HSV_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid && s_axis_tready)

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none

module tb_top;
  import hsv2rgb_pkg::*;

  localparam int IN_W = 32;
  localparam int OUT_W = 24;
  localparam longint unsigned MAXC = 255;
  localparam longint unsigned SECT = 960;
  localparam longint unsigned CIRCLE = 5760;
  localparam int N_RANDOM = 1900;

  typedef struct packed {
    logic [12:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } hsv_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  wire logic        s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;  // hue, saturation, brightness
  wire logic        m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  wire [OUT_W-1:0]  m_axis_tdata;       // red, green, blue

  hsv_t hsv_pending_q[$];
  rgb_t rgb_expected_q[$];
  hsv_t hsv_on_bus;
  int   sent_cnt = 0;
  int   rcv_cnt = 0;
  int   fail_cnt = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  hsv_to_rgb_converter DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic rgb_t predict_rgb(hsv_t px);
    longint unsigned h, s, v, chroma, pos, dev, second, offs, rp, gp, bp;
    sector_t sec;
    rgb_t o;
    h = longint'(px.hue) % CIRCLE;
    s = longint'(px.sat);
    v = longint'(px.val);
    chroma = v * s;
    pos = h % (2 * SECT);
    dev = (pos >= SECT) ? (pos - SECT) : (SECT - pos);
    second = (chroma * (SECT - dev)) / SECT;
    offs = v * MAXC - chroma;
    sec = sector_t'(h / SECT);
    unique case (sec)
      SEC_RY: begin rp = chroma; gp = second; bp = 0; end
      SEC_YG: begin rp = second; gp = chroma; bp = 0; end
      SEC_GC: begin rp = 0; gp = chroma; bp = second; end
      SEC_CB: begin rp = 0; gp = second; bp = chroma; end
      SEC_BM: begin rp = second; gp = 0; bp = chroma; end
      default: begin rp = chroma; gp = 0; bp = second; end
    endcase
    o.red = 8'((rp + offs) / MAXC);
    o.green = 8'((gp + offs) / MAXC);
    o.blue = 8'((bp + offs) / MAXC);
    return o;
  endfunction

  task automatic queue_pixel(int h, int s, int v);
    hsv_t px;
    px.hue = 13'(h);
    px.sat = 8'(s);
    px.val = 8'(v);
    hsv_pending_q.push_back(px);
  endtask

  task automatic check_channel(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  function automatic int pick_color();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 30) return 255;
    return $urandom_range(255);
  endfunction

  // sender
  always @(posedge clk) begin
    hsv_t nx;
    logic idle;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rgb_expected_q.push_back(predict_rgb(hsv_on_bus));
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        idle = ($urandom_range(99) < 20) && !(sent_cnt >= 700 && sent_cnt < 1000)
               && (hold_left == 0);
        if (hsv_pending_q.size() > 0 && !idle) begin
          nx = hsv_pending_q.pop_front();
          hsv_on_bus = nx;
          s_axis_tdata <= {3'b000, nx.val, nx.sat, nx.hue};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the pipeline fills and backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && rcv_cnt >= 1200) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) &&
                       ((rcv_cnt >= 700 && rcv_cnt < 1000) || $urandom_range(99) >= 20);
    end
  end

  // monitor
  always @(posedge clk) begin
    rgb_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      rcv_cnt <= rcv_cnt + 1;
      if (rgb_expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        fail_cnt++;
      end else begin
        want = rgb_expected_q.pop_front();
        check_channel("red", want.red, got.red);
        check_channel("green", want.green, got.green);
        check_channel("blue", want.blue, got.blue);
      end
    end
  end

  initial begin
    int h, r;
    // sector edges, hue wrap, zero saturation, black, full white
    queue_pixel(0, 255, 255);
    queue_pixel(959, 255, 255);
    queue_pixel(960, 255, 255);
    queue_pixel(1919, 255, 255);
    queue_pixel(1920, 255, 255);
    queue_pixel(2879, 200, 255);
    queue_pixel(2880, 255, 128);
    queue_pixel(3840, 255, 255);
    queue_pixel(4800, 255, 255);
    queue_pixel(5759, 255, 255);
    queue_pixel(5760, 255, 255);
    queue_pixel(6720, 180, 90);
    queue_pixel(8191, 255, 255);
    queue_pixel(4095, 1, 254);
    queue_pixel(4096, 254, 1);
    queue_pixel(1000, 0, 255);
    queue_pixel(3000, 0, 77);
    queue_pixel(2000, 255, 0);
    queue_pixel(0, 0, 0);
    queue_pixel(8191, 0, 0);
    queue_pixel(480, 128, 128);
    queue_pixel(5000, 85, 170);
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(99);
      if (r < 80) begin
        h = $urandom_range(5759);
      end else if (r < 88) begin
        h = 960 * $urandom_range(6) + $urandom_range(2) - 1;
        if (h < 0) h = 0;
      end else begin
        h = $urandom_range(8191, 5760);
      end
      queue_pixel(h, pick_color(), pick_color());
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (hsv_pending_q.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (rgb_expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+src
src/hsv2rgb_pkg.sv
src/hsv_to_rgb_converter.sv
sim/tb_top.sv
